FILE: hdl/gflep_pkg.sv
// Shared types, codes and constants for the GF(2^m) log/antilog/power unit.
// Used by gflep_tables and gf2m_log_exp_power_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gflep_pkg;

  localparam int MAX_FIELD_BITS = 8;
  localparam int ELEM_W = 8;
  localparam int POLY_W = 9;
  localparam int DEG_W = 4;
  localparam int PROD_W = 16;
  localparam int TABLE_DEPTH = 256;
  localparam logic [POLY_W-1:0] RESET_POLY = 9'd285;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_LOG = 2'd0;
  localparam logic [1:0] MODE_ALOG = 2'd1;
  localparam logic [1:0] MODE_POW = 2'd2;
  localparam logic [1:0] MODE_COSET = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [ELEM_W-1:0] operand_a;
    logic [ELEM_W-1:0] power_exponent;
  } req_t;

  typedef struct packed {
    logic [ELEM_W-1:0] result;
    logic out_of_range;
  } rsp_t;

  typedef enum logic {
    ST_BUILD,
    ST_RUN
  } build_state_t;

  // Status that the table block reports to the datapath.
  typedef struct packed {
    logic building;
    logic [DEG_W-1:0] degree;
  } tbl_status_t;

  // Position of the top set bit of a polynomial mask.
  function automatic logic [DEG_W-1:0] poly_degree(input logic [POLY_W-1:0] p);
    logic [DEG_W-1:0] d;
    d = '0;
    for (int i = 1; i < POLY_W; i++) begin
      if (p[i]) d = DEG_W'(i);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gflep_tables.sv
// Log and antilog table memories with the sequencer that rebuilds them.
// Depends on gflep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gflep_tables (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [gflep_pkg::POLY_W-1:0] cfg_data,
  input  wire logic log_rd_en,
  input  wire logic [gflep_pkg::ELEM_W-1:0] log_rd_addr,
  output logic [gflep_pkg::ELEM_W-1:0] log_rd_data,
  output logic log_rd_hit,
  input  wire logic alog_rd_en,
  input  wire logic [gflep_pkg::ELEM_W-1:0] alog_rd_addr,
  output logic [gflep_pkg::ELEM_W-1:0] alog_rd_data,
  output gflep_pkg::tbl_status_t status
);

  gflep_pkg::build_state_t state, state_next;
  logic [gflep_pkg::DEG_W-1:0] degree;
  logic [gflep_pkg::ELEM_W-1:0] red;
  logic [gflep_pkg::ELEM_W-1:0] elem, elem_next;
  logic [gflep_pkg::ELEM_W-1:0] step;
  logic [gflep_pkg::TABLE_DEPTH-1:0] log_valid;

  logic [gflep_pkg::ELEM_W-1:0] log_mem [gflep_pkg::TABLE_DEPTH];
  logic [gflep_pkg::ELEM_W-1:0] alog_mem [gflep_pkg::TABLE_DEPTH];

  logic [gflep_pkg::DEG_W-1:0] cfg_deg;
  logic [gflep_pkg::POLY_W-1:0] cfg_mask;
  logic [gflep_pkg::POLY_W-1:0] size9, mask9, dbl;
  logic restart, last_step;

  // Decode a polynomial write; degree zero names no field.
  always_comb begin
    cfg_deg = gflep_pkg::poly_degree(cfg_data);
    cfg_mask = (9'd1 << cfg_deg) - 9'd1;
    restart = cfg_we && (cfg_deg != '0);
  end

  // One multiply-by-x step of the field generator per build cycle.
  always_comb begin
    size9 = 9'd1 << degree;
    mask9 = size9 - 9'd1;
    dbl = {elem, 1'b0};
    if ((dbl & size9) != '0) begin
      elem_next = gflep_pkg::ELEM_W'((dbl & mask9) ^ {1'b0, red});
    end else begin
      elem_next = gflep_pkg::ELEM_W'(dbl);
    end
    last_step = ({1'b0, step} == (size9 - 9'd2));
  end

  // Next state of the build sequencer.
  always_comb begin
    state_next = state;
    case (state)
      gflep_pkg::ST_BUILD: begin
        if (last_step) state_next = gflep_pkg::ST_RUN;
      end
      gflep_pkg::ST_RUN: begin
        state_next = gflep_pkg::ST_RUN;
      end
      default: state_next = gflep_pkg::ST_RUN;
    endcase
    if (restart) state_next = gflep_pkg::ST_BUILD;
  end

  // Sequencer registers and the log valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gflep_pkg::ST_BUILD;
      degree <= gflep_pkg::poly_degree(gflep_pkg::RESET_POLY);
      red <= gflep_pkg::RESET_POLY[gflep_pkg::ELEM_W-1:0];
      elem <= gflep_pkg::ELEM_W'(1);
      step <= '0;
      log_valid <= '0;
    end else begin
      state <= state_next;
      if (restart) begin
        degree <= cfg_deg;
        red <= gflep_pkg::ELEM_W'(cfg_data & cfg_mask);
        elem <= gflep_pkg::ELEM_W'(1);
        step <= '0;
        log_valid <= '0;
      end else if (state == gflep_pkg::ST_BUILD) begin
        elem <= elem_next;
        step <= step + gflep_pkg::ELEM_W'(1);
        log_valid[elem] <= 1'b1;
      end
    end
  end

  // Table writes during a build; a repeated element keeps its later degree.
  always_ff @(posedge clk) begin
    if (state == gflep_pkg::ST_BUILD && !restart) begin
      log_mem[elem] <= step;
      alog_mem[step] <= elem;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    if (log_rd_en) begin
      log_rd_data <= log_mem[log_rd_addr];
      log_rd_hit <= log_valid[log_rd_addr];
    end
    if (alog_rd_en) begin
      alog_rd_data <= alog_mem[alog_rd_addr];
    end
  end

  assign status.building = (state == gflep_pkg::ST_BUILD);
  assign status.degree = degree;

endmodule

`default_nettype wire

FILE: hdl/gf2m_log_exp_power_unit.sv
// Top level of the GF(2^m) log/antilog/power/coset-leader unit.
// Depends on gflep_pkg and gflep_tables.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one word per cycle while req_stall is low and returns one word
// per word, in order; the stages are the input register, the log memory read,
// the exponent multiply, two stages of modular folding and the antilog memory
// read. After reset, and after every write of a polynomial with a set bit
// above bit 0, the tables are rebuilt, one generator step a cycle, and
// req_stall stays high meanwhile. Writes of 0 or 1 are ignored. Write the
// polynomial only while the unit is idle.
module gf2m_log_exp_power_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [gflep_pkg::POLY_W-1:0] cfg_data,
  input  wire logic req_valid,
  output logic req_stall,
  input  wire gflep_pkg::req_t req,
  output logic rsp_valid,
  input  wire logic rsp_stall,
  output gflep_pkg::rsp_t rsp
);

  typedef struct packed {
    logic [1:0] mode;
    logic [gflep_pkg::ELEM_W-1:0] a;
    logic a_zero;
    logic k_zero;
    logic oor;
    logic [gflep_pkg::ELEM_W-1:0] aux;
  } stage_t;

  gflep_pkg::tbl_status_t tstat;
  logic [gflep_pkg::ELEM_W-1:0] log_data, alog_data;
  logic log_hit;

  logic en1, en2, en3, en4, en5, en6, accept;
  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  gflep_pkg::req_t s1_req;
  stage_t s2_ctl, s3_ctl, s4_ctl, s5_ctl, s6_ctl, s2_in, s3_in;
  logic [gflep_pkg::ELEM_W-1:0] s2_k;
  logic [gflep_pkg::PROD_W-1:0] s3_prod, s4_fold;
  logic [gflep_pkg::PROD_W-1:0] f4, f5;
  logic [gflep_pkg::ELEM_W-1:0] s5_deg, deg_next, alog_addr;
  logic [gflep_pkg::ELEM_W-1:0] log_val;

  logic [gflep_pkg::DEG_W-1:0] m;
  logic [gflep_pkg::POLY_W-1:0] size9, order9;
  logic [gflep_pkg::ELEM_W-1:0] mask8, rot, best;

  gflep_tables u_tables (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .log_rd_en(en2),
    .log_rd_addr(s1_req.operand_a),
    .log_rd_data(log_data),
    .log_rd_hit(log_hit),
    .alog_rd_en(en6),
    .alog_rd_addr(alog_addr),
    .alog_rd_data(alog_data),
    .status(tstat)
  );

  // One fold of a value modulo 2^m - 1.
  function automatic logic [gflep_pkg::PROD_W-1:0] fold(
    input logic [gflep_pkg::PROD_W-1:0] p,
    input logic [gflep_pkg::DEG_W-1:0] deg
  );
    logic [gflep_pkg::PROD_W-1:0] msk;
    msk = (16'd1 << deg) - 16'd1;
    return (p >> deg) + (p & msk);
  endfunction

  // Field size and group order for the current degree.
  always_comb begin
    m = tstat.degree;
    size9 = 9'd1 << m;
    order9 = size9 - 9'd1;
    mask8 = gflep_pkg::ELEM_W'(order9);
  end

  // Stage enables: a stage moves when it is empty or its successor moves.
  always_comb begin
    en6 = !s6_v || !rsp_stall;
    en5 = !s5_v || en6;
    en4 = !s4_v || en5;
    en3 = !s3_v || en4;
    en2 = !s2_v || en3;
    en1 = !s1_v || en2;
    req_stall = tstat.building || !en1;
    accept = req_valid && !req_stall;
  end

  // Range check and coset leader over the m cyclic rotations.
  always_comb begin
    rot = s1_req.operand_a & mask8;
    best = rot;
    for (int i = 1; i < gflep_pkg::MAX_FIELD_BITS; i++) begin
      if (i < int'(m)) begin
        rot = ((rot << 1) | {7'b0, rot[3'(m - 4'd1)]}) & mask8;
        if (rot < best) best = rot;
      end
    end
    s2_in.mode = s1_req.mode;
    s2_in.a = s1_req.operand_a;
    s2_in.a_zero = (s1_req.operand_a == '0);
    s2_in.k_zero = (s1_req.power_exponent == '0);
    if (s1_req.mode == gflep_pkg::MODE_LOG || s1_req.mode == gflep_pkg::MODE_POW) begin
      s2_in.oor = ({1'b0, s1_req.operand_a} >= size9);
    end else begin
      s2_in.oor = ({1'b0, s1_req.operand_a} >= order9);
    end
    s2_in.aux = best;
  end

  // Log value of the operand; log mode keeps it as its answer.
  always_comb begin
    log_val = log_hit ? log_data : '0;
    s3_in = s2_ctl;
    if (s2_ctl.mode == gflep_pkg::MODE_LOG) s3_in.aux = log_val;
  end

  // Modular reduction of the exponent product, split over two stages.
  always_comb begin
    f4 = s3_prod;
    for (int i = 0; i < 4; i++) f4 = fold(f4, m);
    f5 = s4_fold;
    for (int i = 0; i < 3; i++) f5 = fold(f5, m);
    if (order9 == 9'd1) begin
      deg_next = '0;
    end else if (f5 >= 16'(order9)) begin
      deg_next = gflep_pkg::ELEM_W'(f5 - 16'(order9));
    end else begin
      deg_next = gflep_pkg::ELEM_W'(f5);
    end
  end

  assign alog_addr = (s5_ctl.mode == gflep_pkg::MODE_ALOG) ? s5_ctl.a : s5_deg;

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else begin
      if (en1) s1_v <= accept;
      if (en2) s2_v <= s1_v;
      if (en3) s3_v <= s2_v;
      if (en4) s4_v <= s3_v;
      if (en5) s5_v <= s4_v;
      if (en6) s6_v <= s5_v;
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (en1 && accept) s1_req <= req;
    if (en2) begin
      s2_ctl <= s2_in;
      s2_k <= s1_req.power_exponent;
    end
    if (en3) begin
      s3_ctl <= s3_in;
      s3_prod <= log_val * s2_k;
    end
    if (en4) begin
      s4_ctl <= s3_ctl;
      s4_fold <= f4;
    end
    if (en5) begin
      s5_ctl <= s4_ctl;
      s5_deg <= deg_next;
    end
    if (en6) s6_ctl <= s5_ctl;
  end

  // Result word from the last stage and the antilog read.
  always_comb begin
    rsp_valid = s6_v;
    rsp.out_of_range = s6_ctl.oor;
    rsp.result = '0;
    if (!s6_ctl.oor) begin
      case (s6_ctl.mode)
        gflep_pkg::MODE_LOG: rsp.result = s6_ctl.aux;
        gflep_pkg::MODE_ALOG: rsp.result = alog_data;
        gflep_pkg::MODE_POW: begin
          if (s6_ctl.a_zero) begin
            rsp.result = {7'b0, s6_ctl.k_zero};
          end else begin
            rsp.result = alog_data;
          end
        end
        gflep_pkg::MODE_COSET: rsp.result = s6_ctl.aux;
        default: rsp.result = '0;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_in_build: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |-> !tstat.building)
    else $error("word accepted during a table build");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.out_of_range) |-> (rsp.result == '0))
    else $error("out-of-range word with nonzero result");

  a_deg_reduced: assert property (@(posedge clk) disable iff (rst)
    (s5_v && s5_ctl.mode == gflep_pkg::MODE_POW && order9 > 9'd1)
      |-> ({1'b0, s5_deg} < order9))
    else $error("power degree not reduced below the group order");
`endif

endmodule

`default_nettype wire
